// ===== design/lens_distortion_correction_defines.svh =====
// Assertion macros shared by the lens distortion correction checker.
`ifndef LENS_DISTORTION_CORRECTION_DEFINES_SVH
`define LENS_DISTORTION_CORRECTION_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define LDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define LDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ldc_pkg.sv =====
// Types and constants shared by the lens distortion correction block.
`timescale 1ns / 1ps

package ldc_pkg;

   localparam int PIPE_DEPTH      = 13;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIAL_K1     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIAL_K2     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TANGENTIAL_P1 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TANGENTIAL_P2 = 3'd5;

   localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] OUT_MIN = 24'sh800000;

   typedef struct packed {
      logic [15:0] point_x;
      logic [15:0] point_y;
   } ldc_req_type;

   typedef struct packed {
      logic signed [23:0] corrected_x;
      logic signed [23:0] corrected_y;
      logic               saturated;
   } ldc_rsp_type;

   // Coefficients are held as magnitude and sign.
   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [31:0] k1_mag;
      logic        k1_neg;
      logic [31:0] k2_mag;
      logic        k2_neg;
      logic [31:0] p1_mag;
      logic        p1_neg;
      logic [31:0] p2_mag;
      logic        p2_neg;
   } ldc_coef_type;

endpackage

// ===== design/ldc_csr.sv =====
// Configuration registers of the lens distortion correction block.
`timescale 1ns / 1ps

module ldc_csr #(
   parameter int COORD_FRAC_BITS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ldc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ldc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output ldc_pkg::ldc_coef_type               coef
);
   import ldc_pkg::*;

   localparam int CX_SHIFTED = 320 * (2 ** COORD_FRAC_BITS);
   localparam int CY_SHIFTED = 240 * (2 ** COORD_FRAC_BITS);
   localparam logic [15:0] CENTER_X_RESET = (CX_SHIFTED > 65535) ? 16'hFFFF : 16'(CX_SHIFTED);
   localparam logic [15:0] CENTER_Y_RESET = (CY_SHIFTED > 65535) ? 16'hFFFF : 16'(CY_SHIFTED);
   localparam ldc_coef_type COEF_RESET = '{
      center_x: CENTER_X_RESET,
      center_y: CENTER_Y_RESET,
      default:  '0
   };

   ldc_coef_type                coef_ff;
   ldc_coef_type                coef_in;
   logic [CSR_DATA_WIDTH-1:0]   data_mag;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;
   assign data_mag  = csr_data[CSR_DATA_WIDTH-1] ? (~csr_data + 1'b1) : csr_data;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_X: begin
               coef_in.center_x = csr_data[15:0];
            end
            CSR_CENTER_Y: begin
               coef_in.center_y = csr_data[15:0];
            end
            CSR_RADIAL_K1: begin
               coef_in.k1_mag = data_mag;
               coef_in.k1_neg = csr_data[CSR_DATA_WIDTH-1];
            end
            CSR_RADIAL_K2: begin
               coef_in.k2_mag = data_mag;
               coef_in.k2_neg = csr_data[CSR_DATA_WIDTH-1];
            end
            CSR_TANGENTIAL_P1: begin
               coef_in.p1_mag = data_mag;
               coef_in.p1_neg = csr_data[CSR_DATA_WIDTH-1];
            end
            CSR_TANGENTIAL_P2: begin
               coef_in.p2_mag = data_mag;
               coef_in.p2_neg = csr_data[CSR_DATA_WIDTH-1];
            end
            default: begin
               coef_in = coef_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== design/lens_distortion_correction.sv =====
// Top level of the pipelined Brown-Conrady lens distortion correction block.
// Each item is a point in unsigned fixed point with COORD_FRAC_BITS fraction bits; the block
// subtracts the distortion center and returns the corrected point relative to that center,
// with radial terms k1*r2 and k2*r2*r2 and tangential terms p1 and p2, saturated to 24 bits.
// The datapath is a 13-stage pipeline, so one point is accepted per clock unless the
// pipeline is full and the result side stalls; the longest chain is the k2 term fed into
// the radial scale. Each stage has its own valid bit and load enable, so bubbles fill up
// while the output is stalled. Registers are written through the csr port (index 0
// center_x, 1 center_y, 2 radial_k1, 3 radial_k2, 4 tangential_p1, 5 tangential_p2); the user
// must write them only while no item is in flight, and the block itself does not enforce it.
// The centers reset to pixel 320,240 and the coefficients to zero.
`timescale 1ns / 1ps

module lens_distortion_correction #(
   parameter int COORD_FRAC_BITS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ldc_pkg::ldc_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ldc_pkg::ldc_rsp_type                rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ldc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ldc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import ldc_pkg::*;

   localparam int SHIFT_A   = 8 + 2 * COORD_FRAC_BITS;
   localparam int SHIFT_K   = 14 + 2 * COORD_FRAC_BITS;
   localparam int SHIFT_T   = 30 + COORD_FRAC_BITS;
   localparam int RAD_SHIFT = 32;
   localparam logic [66:0] HALF_A = 67'(1) << (SHIFT_A - 1);
   localparam logic [66:0] HALF_K = 67'(1) << (SHIFT_K - 1);
   localparam logic [66:0] HALF_T = 67'(1) << (SHIFT_T - 1);
   localparam logic [83:0] HALF_B = 84'(1) << (SHIFT_K - 1);
   localparam logic [79:0] HALF_R = 80'(1) << (RAD_SHIFT - 1);

   ldc_coef_type coef;

   ldc_csr #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] stage_en;

   always_comb begin
      stage_en[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   // Stage 1: offsets from the center.
   logic signed [16:0] s1_dx_in, s1_dy_in, s1_dx_ff, s1_dy_ff;

   assign s1_dx_in = $signed({1'b0, req_payload.point_x}) - $signed({1'b0, coef.center_x});
   assign s1_dy_in = $signed({1'b0, req_payload.point_y}) - $signed({1'b0, coef.center_y});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
   end

   // Stage 2: squares and magnitudes.
   logic signed [33:0] dx_sq, dy_sq;
   logic        [31:0] s2_dx2_ff, s2_dy2_ff;
   logic        [15:0] s2_dxm_in, s2_dym_in, s2_dxm_ff, s2_dym_ff;
   logic signed [16:0] s2_dx_ff, s2_dy_ff;

   assign dx_sq     = s1_dx_ff * s1_dx_ff;
   assign dy_sq     = s1_dy_ff * s1_dy_ff;
   assign s2_dxm_in = s1_dx_ff[16] ? 16'(-s1_dx_ff) : s1_dx_ff[15:0];
   assign s2_dym_in = s1_dy_ff[16] ? 16'(-s1_dy_ff) : s1_dy_ff[15:0];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_dx2_ff <= dx_sq[31:0];
         s2_dy2_ff <= dy_sq[31:0];
         s2_dxm_ff <= s2_dxm_in;
         s2_dym_ff <= s2_dym_in;
         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
      end
   end

   // Stage 3: r2, tangential operands and 2*dx*dy.
   logic        [32:0] s3_r2_in, s3_r2_ff;
   logic        [33:0] s3_ux_in, s3_uy_in, s3_ux_ff, s3_uy_ff;
   logic        [32:0] s3_vmag_in, s3_vmag_ff;
   logic               s3_vneg_ff;
   logic        [15:0] s3_dxm_ff, s3_dym_ff;
   logic signed [16:0] s3_dx_ff, s3_dy_ff;

   assign s3_r2_in   = 33'(s2_dx2_ff) + 33'(s2_dy2_ff);
   assign s3_ux_in   = 34'({s2_dx2_ff, 1'b0}) + 34'(s2_dx2_ff) + 34'(s2_dy2_ff);
   assign s3_uy_in   = 34'({s2_dy2_ff, 1'b0}) + 34'(s2_dy2_ff) + 34'(s2_dx2_ff);
   assign s3_vmag_in = {32'(s2_dxm_ff) * 32'(s2_dym_ff), 1'b0};

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_r2_ff   <= s3_r2_in;
         s3_ux_ff   <= s3_ux_in;
         s3_uy_ff   <= s3_uy_in;
         s3_vmag_ff <= s3_vmag_in;
         s3_vneg_ff <= s2_dx_ff[16] ^ s2_dy_ff[16];
         s3_dxm_ff  <= s2_dxm_ff;
         s3_dym_ff  <= s2_dym_ff;
         s3_dx_ff   <= s2_dx_ff;
         s3_dy_ff   <= s2_dy_ff;
      end
   end

   // Stage 4: coefficient products.
   logic        [64:0] s4_prod_a_ff, s4_prod_k_ff, s4_prod_tx2_ff, s4_prod_ty2_ff;
   logic        [65:0] s4_prod_tx1_ff, s4_prod_ty1_ff;
   logic        [32:0] s4_r2_ff;
   logic               s4_vneg_ff;
   logic        [15:0] s4_dxm_ff, s4_dym_ff;
   logic signed [16:0] s4_dx_ff, s4_dy_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_prod_a_ff   <= 65'(coef.k1_mag) * 65'(s3_r2_ff);
         s4_prod_k_ff   <= 65'(coef.k2_mag) * 65'(s3_r2_ff);
         s4_prod_tx1_ff <= 66'(coef.p2_mag) * 66'(s3_ux_ff);
         s4_prod_ty1_ff <= 66'(coef.p1_mag) * 66'(s3_uy_ff);
         s4_prod_tx2_ff <= 65'(coef.p1_mag) * 65'(s3_vmag_ff);
         s4_prod_ty2_ff <= 65'(coef.p2_mag) * 65'(s3_vmag_ff);
         s4_r2_ff       <= s3_r2_ff;
         s4_vneg_ff     <= s3_vneg_ff;
         s4_dxm_ff      <= s3_dxm_ff;
         s4_dym_ff      <= s3_dym_ff;
         s4_dx_ff       <= s3_dx_ff;
         s4_dy_ff       <= s3_dy_ff;
      end
   end

   // Stage 5: rounded scaling of the products.
   logic        [56:0] s5_a_mag_in, s5_a_mag_ff;
   logic        [49:0] s5_k2r_in, s5_k2r_ff;
   logic        [35:0] s5_tx1_in, s5_ty1_in, s5_tx2_in, s5_ty2_in;
   logic        [35:0] s5_tx1_ff, s5_ty1_ff, s5_tx2_ff, s5_ty2_ff;
   logic               s5_tx2_neg_ff, s5_ty2_neg_ff;
   logic        [32:0] s5_r2_ff;
   logic        [15:0] s5_dxm_ff, s5_dym_ff;
   logic signed [16:0] s5_dx_ff, s5_dy_ff;

   assign s5_a_mag_in = 57'((67'(s4_prod_a_ff) + HALF_A) >> SHIFT_A);
   assign s5_k2r_in   = 50'((67'(s4_prod_k_ff) + HALF_K) >> SHIFT_K);
   assign s5_tx1_in   = 36'((67'(s4_prod_tx1_ff) + HALF_T) >> SHIFT_T);
   assign s5_ty1_in   = 36'((67'(s4_prod_ty1_ff) + HALF_T) >> SHIFT_T);
   assign s5_tx2_in   = 36'((67'(s4_prod_tx2_ff) + HALF_T) >> SHIFT_T);
   assign s5_ty2_in   = 36'((67'(s4_prod_ty2_ff) + HALF_T) >> SHIFT_T);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_a_mag_ff   <= s5_a_mag_in;
         s5_k2r_ff     <= s5_k2r_in;
         s5_tx1_ff     <= s5_tx1_in;
         s5_ty1_ff     <= s5_ty1_in;
         s5_tx2_ff     <= s5_tx2_in;
         s5_ty2_ff     <= s5_ty2_in;
         s5_tx2_neg_ff <= coef.p1_neg ^ s4_vneg_ff;
         s5_ty2_neg_ff <= coef.p2_neg ^ s4_vneg_ff;
         s5_r2_ff      <= s4_r2_ff;
         s5_dxm_ff     <= s4_dxm_ff;
         s5_dym_ff     <= s4_dym_ff;
         s5_dx_ff      <= s4_dx_ff;
         s5_dy_ff      <= s4_dy_ff;
      end
   end

   // Stage 6: signed first radial term, k2 partial products, tangential sums.
   logic signed [57:0] s6_a_in, s6_a_ff;
   logic        [64:0] s6_pp_lo_ff;
   logic        [50:0] s6_pp_hi_ff;
   logic signed [37:0] tx1_s, tx2_s, ty1_s, ty2_s;
   logic signed [37:0] s6_tx_ff, s6_ty_ff;
   logic        [15:0] s6_dxm_ff, s6_dym_ff;
   logic signed [16:0] s6_dx_ff, s6_dy_ff;

   assign s6_a_in = coef.k1_neg ? -$signed({1'b0, s5_a_mag_ff}) : $signed({1'b0, s5_a_mag_ff});
   assign tx1_s   = coef.p2_neg ? -$signed({2'b0, s5_tx1_ff}) : $signed({2'b0, s5_tx1_ff});
   assign ty1_s   = coef.p1_neg ? -$signed({2'b0, s5_ty1_ff}) : $signed({2'b0, s5_ty1_ff});
   assign tx2_s   = s5_tx2_neg_ff ? -$signed({2'b0, s5_tx2_ff}) : $signed({2'b0, s5_tx2_ff});
   assign ty2_s   = s5_ty2_neg_ff ? -$signed({2'b0, s5_ty2_ff}) : $signed({2'b0, s5_ty2_ff});

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s6_a_ff     <= s6_a_in;
         s6_pp_lo_ff <= 65'(s5_k2r_ff[31:0]) * 65'(s5_r2_ff);
         s6_pp_hi_ff <= 51'(s5_k2r_ff[49:32]) * 51'(s5_r2_ff);
         s6_tx_ff    <= tx1_s + tx2_s;
         s6_ty_ff    <= ty1_s + ty2_s;
         s6_dxm_ff   <= s5_dxm_ff;
         s6_dym_ff   <= s5_dym_ff;
         s6_dx_ff    <= s5_dx_ff;
         s6_dy_ff    <= s5_dy_ff;
      end
   end

   // Stage 7: second radial term, rounded and capped.
   logic        [83:0] b_sum, b_shift;
   logic        [61:0] s7_b_mag_in, s7_b_mag_ff;
   logic signed [57:0] s7_a_ff;
   logic signed [37:0] s7_tx_ff, s7_ty_ff;
   logic        [15:0] s7_dxm_ff, s7_dym_ff;
   logic signed [16:0] s7_dx_ff, s7_dy_ff;

   assign b_sum       = 84'({s6_pp_hi_ff, 32'b0}) + 84'(s6_pp_lo_ff) + HALF_B;
   assign b_shift     = b_sum >> SHIFT_K;
   assign s7_b_mag_in = (|b_shift[83:62]) ? '1 : b_shift[61:0];

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s7_b_mag_ff <= s7_b_mag_in;
         s7_a_ff     <= s6_a_ff;
         s7_tx_ff    <= s6_tx_ff;
         s7_ty_ff    <= s6_ty_ff;
         s7_dxm_ff   <= s6_dxm_ff;
         s7_dym_ff   <= s6_dym_ff;
         s7_dx_ff    <= s6_dx_ff;
         s7_dy_ff    <= s6_dy_ff;
      end
   end

   // Stage 8: radial scale in Q32.
   logic signed [63:0] b_s;
   logic signed [63:0] s8_rq_in, s8_rq_ff;
   logic signed [37:0] s8_tx_ff, s8_ty_ff;
   logic        [15:0] s8_dxm_ff, s8_dym_ff;
   logic signed [16:0] s8_dx_ff, s8_dy_ff;

   assign b_s      = coef.k2_neg ? -$signed({2'b0, s7_b_mag_ff}) : $signed({2'b0, s7_b_mag_ff});
   assign s8_rq_in = 64'(s7_a_ff) + b_s;

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s8_rq_ff  <= s8_rq_in;
         s8_tx_ff  <= s7_tx_ff;
         s8_ty_ff  <= s7_ty_ff;
         s8_dxm_ff <= s7_dxm_ff;
         s8_dym_ff <= s7_dym_ff;
         s8_dx_ff  <= s7_dx_ff;
         s8_dy_ff  <= s7_dy_ff;
      end
   end

   // Stage 9: magnitude of the radial scale.
   logic        [62:0] s9_rmag_in, s9_rmag_ff;
   logic               s9_rneg_ff;
   logic signed [37:0] s9_tx_ff, s9_ty_ff;
   logic        [15:0] s9_dxm_ff, s9_dym_ff;
   logic signed [16:0] s9_dx_ff, s9_dy_ff;

   assign s9_rmag_in = s8_rq_ff[63] ? 63'(-s8_rq_ff) : s8_rq_ff[62:0];

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         s9_rmag_ff <= s9_rmag_in;
         s9_rneg_ff <= s8_rq_ff[63];
         s9_tx_ff   <= s8_tx_ff;
         s9_ty_ff   <= s8_ty_ff;
         s9_dxm_ff  <= s8_dxm_ff;
         s9_dym_ff  <= s8_dym_ff;
         s9_dx_ff   <= s8_dx_ff;
         s9_dy_ff   <= s8_dy_ff;
      end
   end

   // Stage 10: partial products of the offsets and the radial scale.
   logic        [47:0] s10_xlo_ff, s10_ylo_ff;
   logic        [46:0] s10_xhi_ff, s10_yhi_ff;
   logic               s10_xneg_ff, s10_yneg_ff;
   logic signed [37:0] s10_tx_ff, s10_ty_ff;
   logic signed [16:0] s10_dx_ff, s10_dy_ff;

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         s10_xlo_ff  <= 48'(s9_dxm_ff) * 48'(s9_rmag_ff[31:0]);
         s10_xhi_ff  <= 47'(s9_dxm_ff) * 47'(s9_rmag_ff[62:32]);
         s10_ylo_ff  <= 48'(s9_dym_ff) * 48'(s9_rmag_ff[31:0]);
         s10_yhi_ff  <= 47'(s9_dym_ff) * 47'(s9_rmag_ff[62:32]);
         s10_xneg_ff <= s9_dx_ff[16] ^ s9_rneg_ff;
         s10_yneg_ff <= s9_dy_ff[16] ^ s9_rneg_ff;
         s10_tx_ff   <= s9_tx_ff;
         s10_ty_ff   <= s9_ty_ff;
         s10_dx_ff   <= s9_dx_ff;
         s10_dy_ff   <= s9_dy_ff;
      end
   end

   // Stage 11: rounded radial displacement.
   logic        [46:0] s11_radx_in, s11_rady_in, s11_radx_ff, s11_rady_ff;
   logic               s11_xneg_ff, s11_yneg_ff;
   logic signed [37:0] s11_tx_ff, s11_ty_ff;
   logic signed [16:0] s11_dx_ff, s11_dy_ff;

   assign s11_radx_in = 47'((80'({s10_xhi_ff, 32'b0}) + 80'(s10_xlo_ff) + HALF_R) >> RAD_SHIFT);
   assign s11_rady_in = 47'((80'({s10_yhi_ff, 32'b0}) + 80'(s10_ylo_ff) + HALF_R) >> RAD_SHIFT);

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         s11_radx_ff <= s11_radx_in;
         s11_rady_ff <= s11_rady_in;
         s11_xneg_ff <= s10_xneg_ff;
         s11_yneg_ff <= s10_yneg_ff;
         s11_tx_ff   <= s10_tx_ff;
         s11_ty_ff   <= s10_ty_ff;
         s11_dx_ff   <= s10_dx_ff;
         s11_dy_ff   <= s10_dy_ff;
      end
   end

   // Stage 12: full sums.
   logic signed [47:0] radx_s, rady_s;
   logic signed [49:0] s12_sumx_in, s12_sumy_in, s12_sumx_ff, s12_sumy_ff;

   assign radx_s = s11_xneg_ff ? -$signed({1'b0, s11_radx_ff}) : $signed({1'b0, s11_radx_ff});
   assign rady_s = s11_yneg_ff ? -$signed({1'b0, s11_rady_ff}) : $signed({1'b0, s11_rady_ff});
   assign s12_sumx_in = 50'(s11_dx_ff) + 50'(radx_s) + 50'(s11_tx_ff);
   assign s12_sumy_in = 50'(s11_dy_ff) + 50'(rady_s) + 50'(s11_ty_ff);

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         s12_sumx_ff <= s12_sumx_in;
         s12_sumy_ff <= s12_sumy_in;
      end
   end

   // Stage 13: saturation into the output register.
   logic        over_x, under_x, over_y, under_y;
   ldc_rsp_type rsp_in, rsp_ff;

   assign over_x  = s12_sumx_ff > 50'(OUT_MAX);
   assign under_x = s12_sumx_ff < 50'(OUT_MIN);
   assign over_y  = s12_sumy_ff > 50'(OUT_MAX);
   assign under_y = s12_sumy_ff < 50'(OUT_MIN);

   always_comb begin
      rsp_in.corrected_x = over_x ? OUT_MAX : (under_x ? OUT_MIN : s12_sumx_ff[23:0]);
      rsp_in.corrected_y = over_y ? OUT_MAX : (under_y ? OUT_MIN : s12_sumy_ff[23:0]);
      rsp_in.saturated   = over_x || under_x || over_y || under_y;
   end

   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== design/ldc_checker.sv =====
// Port-level assertions for the lens distortion correction block, with its bind.
`timescale 1ns / 1ps
`include "lens_distortion_correction_defines.svh"

module ldc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ldc_pkg::ldc_rsp_type rsp_payload
);
   import ldc_pkg::*;

   localparam int COUNT_W = $clog2(PIPE_DEPTH + 1);

   logic [COUNT_W-1:0] in_flight_ff;
   logic [COUNT_W-1:0] in_flight_in;

   // Items accepted whose results have not yet been taken.
   assign in_flight_in = in_flight_ff + COUNT_W'(req_valid && req_ready)
                         - COUNT_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   `LDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result item changed or dropped while stalled")

   `LDC_ASSERT_SAME(a_sat_clipped, clock, reset, rsp_valid && rsp_payload.saturated, rsp_payload.corrected_x == OUT_MAX || rsp_payload.corrected_x == OUT_MIN || rsp_payload.corrected_y == OUT_MAX || rsp_payload.corrected_y == OUT_MIN, "saturated flag set without a clipped value")

   `LDC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result item present after reset")

   `LDC_ASSERT_SAME(a_rsp_has_item, clock, reset, rsp_valid, in_flight_ff != '0, "result item without an accepted item")

   `LDC_ASSERT_SAME(a_full_blocks, clock, reset, in_flight_ff == COUNT_W'(PIPE_DEPTH) && !rsp_ready, !req_ready, "item accepted while the pipeline is full and stalled")

endmodule

bind lens_distortion_correction ldc_checker u_ldc_checker (.*);
